[rtl/core/feh_pkg.sv]
// Shared types and constants for the float exponent histogram.
// Used by every module under rtl/core except feh_queue; no dependencies of its own.

package feh_pkg;

    // Default configuration handed to the top-level parameters
    localparam int DEF_NUM_SIGNALS = 16;
    localparam int DEF_NUM_BINS    = 100;
    localparam int DEF_EXP_OFFSET  = 50;
    localparam int DEF_COUNT_WIDTH = 64;

    // Field widths on the stream ports
    localparam int SIG_FW    = 4;
    localparam int VAL_FW    = 32;
    localparam int SLOT_FW   = 7;
    localparam int BIN_FW    = 7;
    localparam int CNT_FW    = 64;
    localparam int S_TDATA_W = 48;   // 43 bits of fields, padded to 6 bytes
    localparam int M_TDATA_W = 72;   // 71 bits of fields, padded to 9 bytes

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request kinds carried on s_tuser
    localparam logic CMD_TALLY = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Counter categories
    typedef enum logic [1:0] {
        CAT_BIN  = 2'd0,
        CAT_ZERO = 2'd1,
        CAT_LOW  = 2'd2,
        CAT_HIGH = 2'd3
    } cat_t;

    // Decoded request, passed front -> queue -> back
    typedef struct packed {
        logic              tally;   // increment the counter
        logic              access;  // counter exists (valid signal and slot)
        cat_t              cat;
        logic [BIN_FW-1:0] bin;
    } op_info_t;

endpackage

[rtl/core/feh_front.sv]
// Front end: takes stream requests, classifies the float and forms the
// counter address. Depends on feh_pkg.

module feh_front #(
    parameter int NUM_SIGNALS = 16,
    parameter int NUM_BINS    = 100,
    parameter int EXP_OFFSET  = 50,
    parameter int ADDR_W      = 11
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [feh_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_full,
    input  logic                          busy,
    output logic                          push,
    output feh_pkg::op_info_t             info,
    output logic [ADDR_W-1:0]             addr
);
    import feh_pkg::*;

    localparam int NUM_SLOTS = NUM_BINS + 3;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int IDX_W     = 10;
    localparam logic signed [IDX_W-1:0] OFF_S = IDX_W'(EXP_OFFSET);
    localparam logic signed [IDX_W-1:0] NB_S  = IDX_W'(NUM_BINS);

    logic [SIG_FW-1:0]  sig;
    logic [VAL_FW-1:0]  bits;
    logic [SLOT_FW-1:0] rd_slot;
    logic               cmd;

    logic [7:0]               ex;
    logic [22:0]              man;
    logic [4:0]               msb_pos;
    logic signed [IDX_W-1:0]  expo;
    logic signed [IDX_W-1:0]  idx;

    cat_t              t_cat, r_cat;
    logic [BIN_FW-1:0] t_bin, r_bin;
    logic [SLOT_W-1:0] t_slot, r_slot, slot;
    logic              sig_ok, slot_ok;

    assign sig     = s_tdata[SIG_FW-1:0];
    assign bits    = s_tdata[SIG_FW +: VAL_FW];
    assign rd_slot = s_tdata[SIG_FW+VAL_FW +: SLOT_FW];
    assign cmd     = s_tuser;

    assign s_tready = !q_full && !busy;
    assign push     = s_tvalid && s_tready;

    assign ex  = bits[30:23];
    assign man = bits[22:0];

    // highest set mantissa bit, for subnormals
    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < 23; i++) begin
            if (man[i]) msb_pos = 5'(i);
        end
    end

    assign expo = (ex != 8'd0) ? $signed({2'b00, ex}) - 10'sd127
                               : $signed({5'b00000, msb_pos}) - 10'sd149;
    assign idx  = expo + OFF_S;

    // tally classification
    always_comb begin
        t_cat  = CAT_BIN;
        t_bin  = idx[BIN_FW-1:0];
        t_slot = SLOT_W'(idx[IDX_W-2:0]);
        if (ex == 8'hFF) begin
            t_cat = CAT_HIGH;
        end else if (ex == 8'd0 && man == 23'd0) begin
            t_cat = CAT_ZERO;
        end else if (idx[IDX_W-1]) begin
            t_cat = CAT_LOW;
        end else if (idx >= NB_S) begin
            t_cat = CAT_HIGH;
        end
        case (t_cat)
            CAT_ZERO: t_slot = SLOT_W'(NUM_BINS);
            CAT_LOW:  t_slot = SLOT_W'(NUM_BINS + 1);
            CAT_HIGH: t_slot = SLOT_W'(NUM_BINS + 2);
            default:  ;
        endcase
        if (t_cat != CAT_BIN) t_bin = '0;
    end

    // read slot decode; slot numbering matches the address layout
    assign slot_ok = 32'(rd_slot) <= 32'(NUM_BINS + 2);
    assign r_slot  = SLOT_W'(rd_slot);

    always_comb begin
        r_cat = CAT_BIN;
        r_bin = '0;
        if (!slot_ok) begin
            r_cat = CAT_BIN;
        end else if (32'(rd_slot) < 32'(NUM_BINS)) begin
            r_bin = rd_slot;
        end else if (32'(rd_slot) == 32'(NUM_BINS)) begin
            r_cat = CAT_ZERO;
        end else if (32'(rd_slot) == 32'(NUM_BINS + 1)) begin
            r_cat = CAT_LOW;
        end else begin
            r_cat = CAT_HIGH;
        end
    end

    assign sig_ok = 32'(sig) < 32'(NUM_SIGNALS);
    assign slot   = (cmd == CMD_TALLY) ? t_slot : r_slot;

    always_comb begin
        info.tally  = (cmd == CMD_TALLY);
        info.access = sig_ok && (cmd == CMD_TALLY || slot_ok);
        info.cat    = (cmd == CMD_TALLY) ? t_cat : r_cat;
        info.bin    = (cmd == CMD_TALLY) ? t_bin : r_bin;
    end

    // address = signal * slots_per_signal + slot
    assign addr = info.access
                ? ADDR_W'(ADDR_W'(sig) * ADDR_W'(NUM_SLOTS) + ADDR_W'(slot))
                : '0;

endmodule

[rtl/core/feh_queue.sv]
// Small FIFO between front and back end.
// Generic payload vector; no package dependencies.

module feh_queue #(
    parameter int W     = 12,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output logic [W-1:0] head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/core/feh_back.sv]
// Back end: counter memory, read-modify-write with one-deep forwarding,
// reset clearing sweep and output register. Depends on feh_pkg.

module feh_back #(
    parameter int NUM_SIGNALS = 16,
    parameter int NUM_BINS    = 100,
    parameter int COUNT_WIDTH = 64,
    parameter int ADDR_W      = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  feh_pkg::op_info_t             q_info,
    input  logic [ADDR_W-1:0]             q_addr,
    output logic                          q_pop,
    output logic                          busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [feh_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser
);
    import feh_pkg::*;

    localparam int MEM_DEPTH = NUM_SIGNALS * (NUM_BINS + 3);

    logic [COUNT_WIDTH-1:0] cnt_mem [MEM_DEPTH];

    // clearing sweep
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // read stage
    logic                   rd_valid_reg;
    op_info_t               rd_info_reg;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic [COUNT_WIDTH-1:0] mem_q_reg;
    logic                   fwd_hit_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    // output register
    logic                   out_valid_reg;
    cat_t                   out_cat_reg;
    logic [BIN_FW-1:0]      out_bin_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;

    logic                   advance, complete, issue, do_inc, wr_en;
    logic [COUNT_WIDTH-1:0] old_count, new_count, res_count, wr_data;
    logic [ADDR_W-1:0]      wr_addr;

    assign advance   = !out_valid_reg || m_tready;
    assign complete  = rd_valid_reg && advance;
    assign issue     = q_valid && !clr_active_reg && (!rd_valid_reg || complete);
    assign q_pop     = issue;
    assign busy      = clr_active_reg;

    assign old_count = fwd_hit_reg ? fwd_data_reg : mem_q_reg;
    assign new_count = old_count + 1'b1;
    assign do_inc    = complete && rd_info_reg.tally && rd_info_reg.access;
    assign res_count = !rd_info_reg.access ? '0
                     : (rd_info_reg.tally ? new_count : old_count);

    assign wr_en   = clr_active_reg || do_inc;
    assign wr_addr = clr_active_reg ? clr_addr_reg : rd_addr_reg;
    assign wr_data = clr_active_reg ? '0 : new_count;

    assign clr_addr_next = clr_addr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (wr_en) cnt_mem[wr_addr] <= wr_data;
        if (issue) mem_q_reg <= cnt_mem[q_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_next;
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1)) clr_active_reg <= 1'b0;
            end
            if (issue) begin
                rd_valid_reg <= 1'b1;
                // the read misses a write to the same counter at this edge
                fwd_hit_reg  <= do_inc && (rd_addr_reg == q_addr);
            end else if (complete) begin
                rd_valid_reg <= 1'b0;
            end
            if (complete) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_info_reg  <= q_info;
            rd_addr_reg  <= q_addr;
            fwd_data_reg <= new_count;
        end
        if (complete) begin
            out_cat_reg   <= rd_info_reg.cat;
            out_bin_reg   <= rd_info_reg.bin;
            out_count_reg <= res_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CNT_FW - BIN_FW){1'b0}},
                       CNT_FW'(out_count_reg), out_bin_reg};
    assign m_tuser  = out_cat_reg;

endmodule

[rtl/core/float_exponent_histogram.sv]
// Path: an accepted request goes through the queue, the read stage and the output register.
// Throughput: one request per cycle sustained while m_tready stays high; the counter memory's
// read-modify-write loop with one-deep write forwarding sets that figure.
// Reset: synchronous, active low; afterward a clearing sweep zeroes the counter
// memory, all NUM_SIGNALS*(NUM_BINS+3) entries (1648 by default), with s_tready low.
// Top level of the float exponent histogram; uses feh_pkg, feh_front,
// feh_queue and feh_back.

module float_exponent_histogram #(
    parameter int NUM_SIGNALS = feh_pkg::DEF_NUM_SIGNALS,
    parameter int NUM_BINS    = feh_pkg::DEF_NUM_BINS,
    parameter int EXP_OFFSET  = feh_pkg::DEF_EXP_OFFSET,
    parameter int COUNT_WIDTH = feh_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [feh_pkg::S_TDATA_W-1:0] s_tdata,  // signal_id[3:0], value_bits[35:4],
                                                    // read_slot[42:36], zero pad
    input  logic                          s_tuser,  // command: 0 tally, 1 read
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [feh_pkg::M_TDATA_W-1:0] m_tdata,  // bin_index[6:0], count[70:7],
                                                    // zero pad
    output logic [1:0]                    m_tuser   // category
);
    import feh_pkg::*;

    // One flat counter memory: each signal owns NUM_BINS bins followed by its
    // zero, clamp-low and clamp-high counters, so a read slot is the offset.
    localparam int MEM_DEPTH = NUM_SIGNALS * (NUM_BINS + 3);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int Q_W       = $bits(op_info_t) + ADDR_W;

    logic              push, q_full, q_valid, q_pop, busy;
    op_info_t          f_info, q_info;
    logic [ADDR_W-1:0] f_addr, q_addr;
    logic [Q_W-1:0]    q_head;

    // Front: decode and classify, push into the queue
    feh_front #(
        .NUM_SIGNALS (NUM_SIGNALS),
        .NUM_BINS    (NUM_BINS),
        .EXP_OFFSET  (EXP_OFFSET),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .info     (f_info),
        .addr     (f_addr)
    );

    // Queue decouples the front from back-end stalls
    feh_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({f_addr, f_info}),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign q_info = q_head[$bits(op_info_t)-1:0];
    assign q_addr = q_head[Q_W-1 -: ADDR_W];

    // Back: counter memory update and result register
    feh_back #(
        .NUM_SIGNALS (NUM_SIGNALS),
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_info   (q_info),
        .q_addr   (q_addr),
        .q_pop    (q_pop),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/feh_checker.sv]
// Port-level checks for float_exponent_histogram, attached by bind.
// Depends on feh_pkg.

module feh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [feh_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);
    import feh_pkg::*;

    // requests accepted but not yet delivered
    logic [3:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 4'(s_tvalid && s_tready)
                                       - 4'(m_tvalid && m_tready);
        end
    end

    // reset starts the clearing sweep, so no request is taken next cycle
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("s_tready high right after reset");

    a_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result without an outstanding request");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_bin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != CAT_BIN |-> m_tdata[BIN_FW-1:0] == '0)
        else $error("bin_index nonzero outside the bin category");

endmodule

bind float_exponent_histogram feh_checker u_feh_checker (.*);

[tb/feh_histogram_check.sv]
`timescale 1ns / 100ps
// Watches both stream channels of float_exponent_histogram, keeps its own copy of
// every counter, predicts each result and compares it. Depends on feh_pkg only.

module feh_histogram_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [feh_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [feh_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]                    m_tuser,
    output int                            requests_seen,
    output int                            results_checked,
    output int                            mismatches
);
    import feh_pkg::*;

    localparam int NSIG        = DEF_NUM_SIGNALS;
    localparam int NBINS       = DEF_NUM_BINS;
    localparam int EXP_OFS     = DEF_EXP_OFFSET;
    localparam int EXP_BIAS    = 127;
    localparam int SUBNORM_EXP = 149;  // subnormal exponent = top mantissa bit - this
    localparam logic [7:0] EXP_INF_NAN = 8'hFF;
    localparam int SLOTS       = NBINS + 3;  // bins, then zero, clamp-low, clamp-high

    typedef struct {
        cat_t              cat;
        logic [BIN_FW-1:0] bin;
        logic [CNT_FW-1:0] count;
    } counter_report_t;

    // counters per signal, laid out like the read slots
    bit [CNT_FW-1:0]  tallies [NSIG][SLOTS];
    counter_report_t  reports [$];

    function automatic void bucket_of(input logic [VAL_FW-1:0] bits, output cat_t cat,
                                      output logic [BIN_FW-1:0] bin);
        logic [7:0]  ex;
        logic [22:0] man;
        int          e;
        int          idx;
        int          p;
        ex  = bits[30:23];
        man = bits[22:0];
        bin = '0;
        if (ex == EXP_INF_NAN) begin
            cat = CAT_HIGH;
        end else if (ex == 8'd0 && man == 23'd0) begin
            cat = CAT_ZERO;
        end else begin
            if (ex != 8'd0) begin
                e = int'(ex) - EXP_BIAS;
            end else begin
                p = 22;
                while (p > 0 && !man[p])
                    p--;
                e = p - SUBNORM_EXP;
            end
            idx = e + EXP_OFS;
            if (idx < 0) begin
                cat = CAT_LOW;
            end else if (idx >= NBINS) begin
                cat = CAT_HIGH;
            end else begin
                cat = CAT_BIN;
                bin = idx[BIN_FW-1:0];
            end
        end
    endfunction

    // Updates the counters for one request and returns the result it must give.
    // Every 4-bit signal id is in range with 16 signals.
    function automatic counter_report_t apply_request(input logic cmd,
            input logic [SIG_FW-1:0] sig, input logic [VAL_FW-1:0] bits,
            input logic [SLOT_FW-1:0] slot);
        counter_report_t rep;
        int              at;
        rep.cat   = CAT_BIN;
        rep.bin   = '0;
        rep.count = '0;
        if (cmd == CMD_TALLY) begin
            bucket_of(bits, rep.cat, rep.bin);
            at = (rep.cat == CAT_BIN) ? int'(rep.bin) : NBINS + int'(rep.cat) - 1;
            tallies[sig][at] = tallies[sig][at] + 1'b1;  // wraps at 2^64
            rep.count = tallies[sig][at];
        end else if (int'(slot) < NBINS) begin
            rep.bin   = slot;
            rep.count = tallies[sig][slot];
        end else if (int'(slot) < SLOTS) begin
            rep.cat   = cat_t'(int'(slot) - NBINS + 1);
            rep.count = tallies[sig][slot];
        end
        // slots past clamp-high read as bin 0, count 0
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_FW-1:0] seen,
                                   input logic [CNT_FW-1:0] wanted);
        // keep the log short when something is badly off
        if (mismatches < 40)
            $display("[%0t] mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                     $time, results_checked, what, seen, wanted);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        counter_report_t want;
        if (aresetn) begin
            // results first: one accepted in this cycle is never for this cycle's request
            if (m_tvalid && m_tready) begin
                if (reports.size() == 0) begin
                    report_mismatch("result with no request outstanding, count",
                                    m_tdata[7 +: CNT_FW], '0);
                end else begin
                    want = reports.pop_front();
                    if (m_tuser !== want.cat)
                        report_mismatch("category", CNT_FW'(m_tuser), CNT_FW'(want.cat));
                    if (m_tdata[BIN_FW-1:0] !== want.bin)
                        report_mismatch("bin_index", CNT_FW'(m_tdata[BIN_FW-1:0]),
                                        CNT_FW'(want.bin));
                    if (m_tdata[BIN_FW +: CNT_FW] !== want.count)
                        report_mismatch("count", m_tdata[BIN_FW +: CNT_FW], want.count);
                end
                results_checked <= results_checked + 1;
            end
            if (s_tvalid && s_tready) begin
                reports.push_back(apply_request(s_tuser, s_tdata[SIG_FW-1:0],
                                                s_tdata[SIG_FW +: VAL_FW],
                                                s_tdata[SIG_FW + VAL_FW +: SLOT_FW]));
                requests_seen <= requests_seen + 1;
            end
        end
    end

endmodule

[tb/tb_float_exponent_histogram.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for float_exponent_histogram: directed corner values, then
// random tallies and reads with random idling on both sides. Uses feh_pkg and
// feh_histogram_check, which does all prediction and comparison.

module tb_float_exponent_histogram;
    import feh_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;      // one long output stall to back up the input
    localparam int HOLD_AFTER   = 300;      // results seen before that stall starts
    localparam int LIMIT_CYCLES = 400_000;  // clearing sweep + worst-case idling, x3
    localparam int DRAIN_CYCLES = 8;        // margin after the last expected result for stray results

    // read slot codes past the bins
    localparam logic [SLOT_FW-1:0] SLOT_ZERO = SLOT_FW'(DEF_NUM_BINS);
    localparam logic [SLOT_FW-1:0] SLOT_LOW  = SLOT_FW'(DEF_NUM_BINS + 1);
    localparam logic [SLOT_FW-1:0] SLOT_HIGH = SLOT_FW'(DEF_NUM_BINS + 2);
    localparam logic [SLOT_FW-1:0] SLOT_MAX  = '1;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // signal_id[3:0], value_bits[35:4],
                                          // read_slot[42:36], zero pad
    logic                 s_tuser  = CMD_TALLY;  // command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // bin_index[6:0], count[70:7], zero pad
    logic [1:0]           m_tuser;        // category

    int requests_seen;
    int results_checked;
    int mismatches;
    int n_sent;
    int n_tally;
    int n_read;
    int n_beyond;  // reads past the clamp-high slot
    int cycles;
    bit steady;    // sender runs without gaps while set

    always #1 aclk = ~aclk;

    float_exponent_histogram dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    feh_histogram_check histogram_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .requests_seen   (requests_seen),
        .results_checked (results_checked),
        .mismatches      (mismatches)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles(input bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Value mix: many land in a narrow band of bins so counts climb and reads
    // find them; the rest covers every bit pattern and the class boundaries.
    function automatic logic [VAL_FW-1:0] pick_value();
        int          r;
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        r   = $urandom_range(0, 99);
        sgn = 1'($urandom_range(0, 1));
        man = 23'($urandom);
        if (r < 30) begin
            ex = 8'($urandom_range(120, 134));        // bins 43..57
        end else if (r < 55) begin
            ex = 8'($urandom_range(77, 176));         // any bin
        end else if (r < 75) begin
            return $urandom;
        end else if (r < 80) begin
            ex  = 8'h00;                              // signed zero
            man = '0;
        end else if (r < 85) begin
            ex = 8'hFF;                               // infinity or NaN
        end else if (r < 90) begin
            ex = 8'h00;                               // subnormal
        end else begin
            case ($urandom_range(0, 5))               // edges of the bin range
                0: ex = 8'd1;
                1: ex = 8'd76;
                2: ex = 8'd77;
                3: ex = 8'd176;
                4: ex = 8'd177;
                default: ex = 8'd254;
            endcase
        end
        return {sgn, ex, man};
    endfunction

    function automatic logic [SLOT_FW-1:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return SLOT_FW'($urandom_range(43, 57));
        if (r < 65) return SLOT_FW'($urandom_range(0, DEF_NUM_BINS - 1));
        if (r < 85) return SLOT_FW'($urandom_range(SLOT_ZERO, SLOT_HIGH));
        return SLOT_FW'($urandom_range(SLOT_HIGH + 1, SLOT_MAX));
    endfunction

    // Holds a request until it is taken, then idles for a gap from idle_cycles.
    task automatic offer(input logic cmd, input logic [SIG_FW-1:0] sig,
                         input logic [VAL_FW-1:0] bits, input logic [SLOT_FW-1:0] slot);
        int gap;
        gap = idle_cycles(steady);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - SIG_FW - VAL_FW - SLOT_FW){1'b0}}, slot, bits, sig};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // read_slot is unused on a tally, so it carries noise
    task automatic tally_value(input logic [SIG_FW-1:0] sig, input logic [VAL_FW-1:0] bits);
        n_tally++;
        offer(CMD_TALLY, sig, bits, SLOT_FW'($urandom_range(0, SLOT_MAX)));
    endtask

    // value_bits is unused on a read, so it carries noise
    task automatic read_counter(input logic [SIG_FW-1:0] sig, input logic [SLOT_FW-1:0] slot);
        n_read++;
        if (slot > SLOT_HIGH) n_beyond++;
        offer(CMD_READ, sig, $urandom, slot);
    endtask

    // Run limit; a hang anywhere lands here.
    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("cycle limit of %0d reached with %0d of %0d results in", LIMIT_CYCLES,
                 results_checked, requests_seen);
        $display("[float_exponent_histogram] ERROR");
        $finish;
    end

    // Result side: random ready stretches and stalls, and once a long hold-off
    // while the sender keeps pushing, so the queue fills and s_tready drops.
    initial begin : result_sink
        bit held;
        held = 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && results_checked >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(60, 150)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            begin : stall
                int gap;
                gap = idle_cycles(1'b0);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        logic               is_read;
        logic [SIG_FW-1:0]  sig;
        logic [VAL_FW-1:0]  bits;
        logic [SLOT_FW-1:0] slot;
        is_read = 1'b0;
        sig     = '0;
        bits    = '0;
        slot    = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every class boundary, both signs, both end signals.
        // Requests sit waiting while the clearing sweep runs.
        tally_value(4'd0,  32'h3F80_0000);   // 1.0 -> bin 50
        tally_value(4'd0,  32'hBF80_0000);   // -1.0 -> bin 50 again, sign ignored
        tally_value(4'd0,  32'h0000_0000);   // +0
        tally_value(4'd0,  32'h8000_0000);   // -0
        tally_value(4'd0,  32'h7F80_0000);   // +inf -> clamp-high
        tally_value(4'd0,  32'hFFC0_0001);   // NaN -> clamp-high
        tally_value(4'd0,  32'h0000_0001);   // smallest subnormal -> clamp-low
        tally_value(4'd0,  32'h807F_FFFF);   // largest subnormal -> clamp-low
        tally_value(4'd0,  32'h0080_0000);   // smallest normal -> clamp-low
        tally_value(4'd0,  32'h2600_0000);   // one exponent below bin 0 -> clamp-low
        tally_value(4'd0,  32'h2680_0000);   // bin 0
        tally_value(4'd0,  32'h587F_FFFF);   // bin 99, full mantissa
        tally_value(4'd0,  32'h5880_0000);   // one past bin 99 -> clamp-high
        tally_value(4'd15, 32'hFF7F_FFFF);   // largest finite, negative -> clamp-high
        tally_value(4'd15, 32'h3F80_0000);
        read_counter(4'd0,  7'd50);
        read_counter(4'd0,  7'd0);
        read_counter(4'd0,  7'd99);
        read_counter(4'd0,  SLOT_ZERO);
        read_counter(4'd0,  SLOT_LOW);
        read_counter(4'd0,  SLOT_HIGH);
        read_counter(4'd0,  SLOT_HIGH + 1'b1);   // first slot past the end
        read_counter(4'd15, SLOT_MAX);
        read_counter(4'd15, 7'd50);
        read_counter(4'd7,  7'd50);              // untouched signal reads zero

        // Random: tallies piled onto a few signals, reads of the live counters,
        // and exact repeats that hit the same counter back to back.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = ((i / 100) % 4) == 1;
            if (i == 0 || $urandom_range(0, 99) >= 15) begin
                is_read = $urandom_range(0, 99) < 30;
                sig     = ($urandom_range(0, 3) != 0) ? SIG_FW'($urandom_range(0, 3))
                                                      : SIG_FW'($urandom_range(0, 15));
                bits    = pick_value();
                slot    = pick_slot();
            end
            if (is_read)
                read_counter(sig, slot);
            else
                tally_value(sig, bits);
        end
        s_tvalid <= 1'b0;

        while (requests_seen != n_sent || results_checked < requests_seen)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d tallies and %0d reads (%0d past the last slot), %0d results",
                 n_tally, n_read, n_beyond, results_checked);
        $display("checked in %0d cycles, including a %0d-cycle output hold-off",
                 cycles, HOLD_CYCLES);
        if (mismatches == 0)
            $display("[float_exponent_histogram] OK");
        else
            $display("[float_exponent_histogram] ERROR");
        $finish;
    end

endmodule
